/* rtl/qapm_pkg.sv */
// Shared types, control word layout and arithmetic constants of the attitude PID mixer.
`default_nettype none

package qapm_pkg;

  localparam int GAIN_W = 24;
  localparam int ANG_W  = 24;
  localparam int STK_W  = 12;
  localparam int MOT_W  = 15;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // shared multiplier: signed A times unsigned B
  localparam int OPA_W  = 25;
  localparam int OPB_W  = 24;
  localparam int PROD_W = OPA_W + OPB_W + 1;

  localparam int XP_W   = 22;   // biased setpoint numerator
  localparam int Q_W    = 16;   // quotient of the setpoint divide
  localparam int SP_W   = 17;
  localparam int RND_SH = 16;
  localparam int INC_W  = PROD_W - RND_SH;
  localparam int INT_W  = 20;
  localparam int LOOP_W = 51;
  localparam int SH_W   = 33;
  localparam int CORR_W = 12;
  localparam int MIX_W  = 53;
  localparam int STEP_W = 5;

  localparam int THR_CUTOFF = 1100;
  localparam int THR_BASE   = 1000;
  localparam int INT_LIM    = 327680;
  localparam int MOTOR_MAX  = 25600;
  localparam int RND16      = 32768;

  // setpoint: floor((384*stick + SP_BIAS) / 50) - SP_OFFS, divide by reciprocal
  localparam int SP_BIAS   = 24025;
  localparam int SP_OFFS   = 12000;
  localparam int REC50     = 2684355;
  localparam int REC50_SH  = 27;

  // throttle shares: t*Ax + ((t*Rx) >> FRAC_SH)
  localparam int A0      = 1644167;
  localparam int R0      = 1409287;
  localparam int A12     = 1677721;
  localparam int R12     = 5033165;
  localparam int A3      = 1593835;
  localparam int R3      = 4362077;
  localparam int FRAC_SH = 23;

  typedef struct packed {
    logic                    reset_integrators;
    logic [STK_W-1:0]        rc_throttle;
    logic [STK_W-1:0]        rc_pitch_stick;
    logic [STK_W-1:0]        rc_roll_stick;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] pitch_rate;
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] roll_rate;
    logic signed [ANG_W-1:0] yaw_rate;
  } in_t;

  typedef struct packed {
    logic [MOT_W-1:0] motor_0;
    logic [MOT_W-1:0] motor_1;
    logic [MOT_W-1:0] motor_2;
    logic [MOT_W-1:0] motor_3;
  } out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp_pitch;
    logic [GAIN_W-1:0] ki_pitch;
    logic [GAIN_W-1:0] kd_pitch;
    logic [GAIN_W-1:0] kp_roll;
    logic [GAIN_W-1:0] ki_roll;
    logic [GAIN_W-1:0] kd_roll;
    logic [GAIN_W-1:0] kp_yaw;
    logic [GAIN_W-1:0] ki_yaw;
  } gains_t;

  typedef enum logic [2:0] {
    A_XP, A_XR, A_EP, A_ER, A_PR, A_RR, A_YR, A_T
  } asel_t;

  typedef enum logic [3:0] {
    B_KP_P, B_KI_P, B_KD_P, B_KP_R, B_KI_R, B_KD_R, B_KP_Y, B_KI_Y,
    B_REC50, B_A0, B_R0, B_A12, B_R12, B_A3, B_R3
  } bsel_t;

  typedef enum logic [4:0] {
    WB_NONE, WB_SP_P, WB_SP_R, WB_INT_P, WB_INT_R, WB_INT_Y,
    WB_ACC_P, WB_ACC_R, WB_ACC_Y, WB_SH0_LD, WB_SH0_ADD, WB_SH12_LD,
    WB_SH12_ADD, WB_SH3_LD, WB_SH3_ADD, WB_MIX, WB_OUT, WB_OUT_ZERO
  } wb_t;

  typedef enum logic [1:0] {
    J_NONE, J_LOW, J_END
  } jmp_t;

  typedef struct packed {
    asel_t             a_sel;
    bsel_t             b_sel;
    wb_t               wb;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   run;
    ucode_t uc;
  } ctl_t;

  typedef struct packed {
    logic low_thr;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/qapm_cfg.sv */
// APB gain register file of the attitude PID mixer.
`default_nettype none

module qapm_cfg
  import qapm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output gains_t            gains
);

  localparam logic [2:0] REG_KP_PITCH = 3'd0;
  localparam logic [2:0] REG_KI_PITCH = 3'd1;
  localparam logic [2:0] REG_KD_PITCH = 3'd2;
  localparam logic [2:0] REG_KP_ROLL  = 3'd3;
  localparam logic [2:0] REG_KI_ROLL  = 3'd4;
  localparam logic [2:0] REG_KD_ROLL  = 3'd5;
  localparam logic [2:0] REG_KP_YAW   = 3'd6;
  localparam logic [2:0] REG_KI_YAW   = 3'd7;

  localparam logic [GAIN_W-1:0] KP_RST = GAIN_W'(29491);
  localparam logic [GAIN_W-1:0] KI_RST = GAIN_W'(16777);
  localparam logic [GAIN_W-1:0] KD_RST = GAIN_W'(13107);

  gains_t            gains_r;
  logic [2:0]        reg_idx;
  logic [GAIN_W-1:0] rd_val;
  logic [GAIN_W-1:0] wr_val;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_val  = pwdata[GAIN_W-1:0];
  assign pready  = 1'b1;
  assign gains   = gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.kp_pitch <= KP_RST;
      gains_r.ki_pitch <= KI_RST;
      gains_r.kd_pitch <= KD_RST;
      gains_r.kp_roll  <= KP_RST;
      gains_r.ki_roll  <= KI_RST;
      gains_r.kd_roll  <= KD_RST;
      gains_r.kp_yaw   <= KP_RST;
      gains_r.ki_yaw   <= KI_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_KP_PITCH: gains_r.kp_pitch <= wr_val;
        REG_KI_PITCH: gains_r.ki_pitch <= wr_val;
        REG_KD_PITCH: gains_r.kd_pitch <= wr_val;
        REG_KP_ROLL:  gains_r.kp_roll  <= wr_val;
        REG_KI_ROLL:  gains_r.ki_roll  <= wr_val;
        REG_KD_ROLL:  gains_r.kd_roll  <= wr_val;
        REG_KP_YAW:   gains_r.kp_yaw   <= wr_val;
        REG_KI_YAW:   gains_r.ki_yaw   <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KP_PITCH: rd_val = gains_r.kp_pitch;
      REG_KI_PITCH: rd_val = gains_r.ki_pitch;
      REG_KD_PITCH: rd_val = gains_r.kd_pitch;
      REG_KP_ROLL:  rd_val = gains_r.kp_roll;
      REG_KI_ROLL:  rd_val = gains_r.ki_roll;
      REG_KD_ROLL:  rd_val = gains_r.kd_roll;
      REG_KP_YAW:   rd_val = gains_r.kp_yaw;
      REG_KI_YAW:   rd_val = gains_r.ki_yaw;
      default:      rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

endmodule

`default_nettype wire

/* rtl/qapm_seq.sv */
// Microcode sequencer: program ROM, step counter and jump logic.
`default_nettype none

module qapm_seq
  import qapm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output ctl_t  ctl,
  output logic  busy
);

  localparam int NUM_STEPS = 20;
  localparam logic [STEP_W-1:0] S_ZERO = STEP_W'(19);
  localparam logic [STEP_W-1:0] S_NONE = STEP_W'(0);

  // Each step issues one product and retires the product issued one step earlier.
  localparam ucode_t ROM [NUM_STEPS] = '{
    '{A_XP, B_REC50, WB_NONE,     J_LOW,  S_ZERO},  // 0: pitch setpoint divide
    '{A_XR, B_REC50, WB_SP_P,     J_NONE, S_NONE},  // 1: roll setpoint divide
    '{A_EP, B_KI_P,  WB_SP_R,     J_NONE, S_NONE},  // 2
    '{A_EP, B_KP_P,  WB_INT_P,    J_NONE, S_NONE},  // 3
    '{A_PR, B_KD_P,  WB_ACC_P,    J_NONE, S_NONE},  // 4
    '{A_ER, B_KI_R,  WB_ACC_P,    J_NONE, S_NONE},  // 5
    '{A_ER, B_KP_R,  WB_INT_R,    J_NONE, S_NONE},  // 6
    '{A_RR, B_KD_R,  WB_ACC_R,    J_NONE, S_NONE},  // 7
    '{A_YR, B_KI_Y,  WB_ACC_R,    J_NONE, S_NONE},  // 8
    '{A_YR, B_KP_Y,  WB_INT_Y,    J_NONE, S_NONE},  // 9
    '{A_T,  B_A0,    WB_ACC_Y,    J_NONE, S_NONE},  // 10: throttle shares
    '{A_T,  B_R0,    WB_SH0_LD,   J_NONE, S_NONE},  // 11
    '{A_T,  B_A12,   WB_SH0_ADD,  J_NONE, S_NONE},  // 12
    '{A_T,  B_R12,   WB_SH12_LD,  J_NONE, S_NONE},  // 13
    '{A_T,  B_A3,    WB_SH12_ADD, J_NONE, S_NONE},  // 14
    '{A_T,  B_R3,    WB_SH3_LD,   J_NONE, S_NONE},  // 15
    '{A_T,  B_R3,    WB_SH3_ADD,  J_NONE, S_NONE},  // 16
    '{A_T,  B_R3,    WB_MIX,      J_NONE, S_NONE},  // 17
    '{A_T,  B_R3,    WB_OUT,      J_END,  S_NONE},  // 18
    '{A_T,  B_R3,    WB_OUT_ZERO, J_END,  S_NONE}   // 19: low throttle
  };

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            uc;
  logic              hold;
  logic              run;

  assign uc   = ROM[step_r];
  // hold the last step while the previous result is still waiting
  assign hold = (uc.jmp == J_END) && stat.out_busy;
  assign run  = busy_r && !hold;

  assign ctl.run = run;
  assign ctl.uc  = uc;
  assign busy    = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (run) begin
      case (uc.jmp)
        J_LOW:   step_nxt = stat.low_thr ? uc.target : step_r + STEP_W'(1);
        J_END:   busy_nxt = 1'b0;
        default: step_nxt = step_r + STEP_W'(1);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/qapm_dp.sv */
// Datapath: operand selection, shared multiplier, integrators, loop sums and motor mix.
`default_nettype none

module qapm_dp
  import qapm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  in_t    item,
  input  gains_t gains,
  input  ctl_t   ctl,
  input  logic   out_stall,
  output stat_t  stat,
  output logic   out_valid,
  output out_t   out_data
);

  function automatic logic [XP_W-1:0] sp_numer(input logic [STK_W-1:0] s);
    return XP_W'({s, 8'd0}) + XP_W'({s, 7'd0}) + XP_W'(SP_BIAS);
  endfunction

  function automatic logic [MOT_W-1:0] motor_level(input logic signed [MIX_W-1:0] m);
    logic signed [MIX_W-1:0]        mr;
    logic signed [MIX_W-RND_SH-1:0] r;
    mr = m + MIX_W'(RND16);
    r  = mr[MIX_W-1:RND_SH];
    if (r < 0)
      return '0;
    else if (r > MOTOR_MAX)
      return MOT_W'(MOTOR_MAX);
    else
      return MOT_W'(r);
  endfunction

  in_t                      item_r;
  logic [XP_W-1:0]          xp_pitch, xp_roll;
  logic [STK_W-1:0]         t_val;
  logic signed [OPA_W-1:0]  opa;
  logic [OPB_W-1:0]         opb;
  logic signed [OPB_W:0]    opb_s;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;

  logic [Q_W-1:0]           sp_q;
  logic signed [SP_W-1:0]   sp;
  logic signed [ANG_W-1:0]  angle_sel;
  logic signed [OPA_W-1:0]  e_nxt, e_p_r, e_r_r;

  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [INC_W-1:0]  inc;
  logic signed [INT_W-1:0]  integ_sel;
  logic signed [INC_W:0]    isum;
  logic signed [INT_W-1:0]  integ_nxt;
  logic signed [INT_W-1:0]  integ_p_r, integ_r_r, integ_y_r;
  logic signed [LOOP_W-1:0] int_scaled;
  logic signed [LOOP_W-1:0] prod_ext;
  logic signed [LOOP_W-1:0] loop_p_r, loop_r_r, loop_y_r;

  logic [SH_W-1:0]          corr;
  logic [SH_W-1:0]          sh0_r, sh12_r, sh3_r;
  logic signed [MIX_W-1:0]  sh0_s, sh12_s, sh3_s, p_s, r_s, y_s;
  logic signed [MIX_W-1:0]  mix0_r, mix1_r, mix2_r, mix3_r;

  logic                     out_valid_r;
  out_t                     out_data_r;
  logic                     fire_out;

  always_ff @(posedge clk) begin
    if (load) item_r <= item;
  end

  assign xp_pitch = sp_numer(item_r.rc_pitch_stick);
  assign xp_roll  = sp_numer(item_r.rc_roll_stick);
  assign t_val    = item_r.rc_throttle - STK_W'(THR_BASE);

  always_comb begin
    case (ctl.uc.a_sel)
      A_XP:    opa = $signed(OPA_W'(xp_pitch));
      A_XR:    opa = $signed(OPA_W'(xp_roll));
      A_EP:    opa = e_p_r;
      A_ER:    opa = e_r_r;
      A_PR:    opa = OPA_W'(item_r.pitch_rate);
      A_RR:    opa = OPA_W'(item_r.roll_rate);
      A_YR:    opa = OPA_W'(item_r.yaw_rate);
      A_T:     opa = $signed(OPA_W'(t_val));
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (ctl.uc.b_sel)
      B_KP_P:  opb = gains.kp_pitch;
      B_KI_P:  opb = gains.ki_pitch;
      B_KD_P:  opb = gains.kd_pitch;
      B_KP_R:  opb = gains.kp_roll;
      B_KI_R:  opb = gains.ki_roll;
      B_KD_R:  opb = gains.kd_roll;
      B_KP_Y:  opb = gains.kp_yaw;
      B_KI_Y:  opb = gains.ki_yaw;
      B_REC50: opb = OPB_W'(REC50);
      B_A0:    opb = OPB_W'(A0);
      B_R0:    opb = OPB_W'(R0);
      B_A12:   opb = OPB_W'(A12);
      B_R12:   opb = OPB_W'(R12);
      B_A3:    opb = OPB_W'(A3);
      B_R3:    opb = OPB_W'(R3);
      default: opb = '0;
    endcase
  end

  assign opb_s    = $signed({1'b0, opb});
  assign prod_nxt = opa * opb_s;

  always_ff @(posedge clk) begin
    if (ctl.run) prod_r <= prod_nxt;
  end

  // error = angle - setpoint, setpoint from the reciprocal product
  assign sp_q      = prod_r[REC50_SH +: Q_W];
  assign sp        = $signed(SP_W'(sp_q)) - SP_W'(SP_OFFS);
  assign angle_sel = (ctl.uc.wb == WB_SP_P) ? item_r.pitch_angle : item_r.roll_angle;
  assign e_nxt     = OPA_W'(angle_sel) - OPA_W'(sp);

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      if (ctl.uc.wb == WB_SP_P) e_p_r <= e_nxt;
      if (ctl.uc.wb == WB_SP_R) e_r_r <= e_nxt;
    end
  end

  // integrator step: round Ki*e to Q.16, add, clamp
  assign prod_rnd = prod_r + PROD_W'(RND16);
  assign inc      = prod_rnd[PROD_W-1:RND_SH];

  always_comb begin
    case (ctl.uc.wb)
      WB_INT_P: integ_sel = integ_p_r;
      WB_INT_R: integ_sel = integ_r_r;
      default:  integ_sel = integ_y_r;
    endcase
  end

  assign isum = (INC_W+1)'(integ_sel) + (INC_W+1)'(inc);

  always_comb begin
    if (isum > (INC_W+1)'(INT_LIM))
      integ_nxt = INT_W'(INT_LIM);
    else if (isum < (INC_W+1)'(-INT_LIM))
      integ_nxt = INT_W'(-INT_LIM);
    else
      integ_nxt = INT_W'(isum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_p_r <= '0;
      integ_r_r <= '0;
      integ_y_r <= '0;
    end else if (load && item.reset_integrators) begin
      integ_p_r <= '0;
      integ_r_r <= '0;
      integ_y_r <= '0;
    end else if (ctl.run) begin
      case (ctl.uc.wb)
        WB_INT_P: integ_p_r <= integ_nxt;
        WB_INT_R: integ_r_r <= integ_nxt;
        WB_INT_Y: integ_y_r <= integ_nxt;
        default: ;
      endcase
    end
  end

  // loop sums start from the integrator in Q.24 and add the products
  assign int_scaled = {(LOOP_W-8)'(integ_nxt), 8'd0};
  assign prod_ext   = LOOP_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      case (ctl.uc.wb)
        WB_INT_P: loop_p_r <= int_scaled;
        WB_INT_R: loop_r_r <= int_scaled;
        WB_INT_Y: loop_y_r <= int_scaled;
        WB_ACC_P: loop_p_r <= loop_p_r + prod_ext;
        WB_ACC_R: loop_r_r <= loop_r_r + prod_ext;
        WB_ACC_Y: loop_y_r <= loop_y_r + prod_ext;
        default: ;
      endcase
    end
  end

  // throttle shares: integer part, then the fractional correction
  assign corr = SH_W'(prod_r[FRAC_SH +: CORR_W]);

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      case (ctl.uc.wb)
        WB_SH0_LD:   sh0_r  <= prod_r[SH_W-1:0];
        WB_SH0_ADD:  sh0_r  <= sh0_r + corr;
        WB_SH12_LD:  sh12_r <= prod_r[SH_W-1:0];
        WB_SH12_ADD: sh12_r <= sh12_r + corr;
        WB_SH3_LD:   sh3_r  <= prod_r[SH_W-1:0];
        WB_SH3_ADD:  sh3_r  <= sh3_r + corr;
        default: ;
      endcase
    end
  end

  assign sh0_s  = $signed(MIX_W'(sh0_r));
  assign sh12_s = $signed(MIX_W'(sh12_r));
  assign sh3_s  = $signed(MIX_W'(sh3_r));
  assign p_s    = MIX_W'(loop_p_r);
  assign r_s    = MIX_W'(loop_r_r);
  assign y_s    = MIX_W'(loop_y_r);

  always_ff @(posedge clk) begin
    if (ctl.run && (ctl.uc.wb == WB_MIX)) begin
      mix0_r <= sh0_s + p_s + r_s + y_s;
      mix1_r <= sh12_s + p_s - r_s - y_s;
      mix2_r <= sh12_s - p_s - r_s + y_s;
      mix3_r <= sh3_s - p_s + r_s - y_s;
    end
  end

  assign fire_out = ctl.run && ((ctl.uc.wb == WB_OUT) || (ctl.uc.wb == WB_OUT_ZERO));

  always_ff @(posedge clk) begin
    if (ctl.run && (ctl.uc.wb == WB_OUT)) begin
      out_data_r.motor_0 <= motor_level(mix0_r);
      out_data_r.motor_1 <= motor_level(mix1_r);
      out_data_r.motor_2 <= motor_level(mix2_r);
      out_data_r.motor_3 <= motor_level(mix3_r);
    end else if (ctl.run && (ctl.uc.wb == WB_OUT_ZERO)) begin
      out_data_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (fire_out)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.low_thr  = (item_r.rc_throttle <= STK_W'(THR_CUTOFF));
  assign stat.out_busy = out_valid_r && out_stall;

endmodule

`default_nettype wire

/* rtl/quad_attitude_pid_mixer.sv */
// Top level of the X-frame attitude PID loops and motor mixer.
// One control tick is taken per transfer on the input channel and yields one transfer of four
// motor levels. A microcoded sequencer drives a single shared 25x25 multiplier through sixteen
// products (two setpoint divides by reciprocal, eight gain products, six throttle-share terms),
// so a normal tick runs the program to its end step before the next tick is taken; a tick at
// or below the throttle cutoff jumps to the step that zeroes the motors. The result sits in an
// output register, so the next tick starts while it waits; the sequencer holds on its last step
// only if the previous result has not yet been taken. Gains are written over the APB port at
// byte address 4*i and should be changed only while the block is idle.
`default_nettype none

module quad_attitude_pid_mixer
  import qapm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  gains_t gains;
  ctl_t   ctl;
  stat_t  stat;
  logic   busy;
  logic   accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  qapm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gains   (gains)
  );

  qapm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  qapm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .item      (in_data),
    .gains     (gains),
    .ctl       (ctl),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the X-frame attitude PID loops and motor mixer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qapm_pkg::*;

  typedef enum int {
    REG_KP_PITCH, REG_KI_PITCH, REG_KD_PITCH, REG_KP_ROLL,
    REG_KI_ROLL, REG_KD_ROLL, REG_KP_YAW, REG_KI_YAW, NUM_GAIN_REGS
  } gain_reg_e;

  typedef enum int {AX_PITCH, AX_ROLL, AX_YAW} axis_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    in_t  tick;
    bit   typed;
    out_t motors;
  } dir_row_t;

  localparam int     STICK_MID     = 1500;
  localparam longint ONE_Q24       = 64'sd16777216;
  localparam int     NUM_PHASES    = 6;
  localparam int     PHASE_TICKS   = 190;
  localparam int     SETTLE_CYCLES = 40;

  localparam logic [GAIN_W-1:0] RESET_GAIN [NUM_GAIN_REGS] =
    '{24'd29491, 24'd16777, 24'd13107, 24'd29491, 24'd16777, 24'd13107, 24'd29491, 24'd16777};

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor state and configuration
  logic [GAIN_W-1:0] gain_regs [NUM_GAIN_REGS];
  longint            integ [3];

  out_t     motor_queue [$];
  dir_row_t dir_rows [$];
  int       fail_count   = 0;
  int       result_count = 0;
  int       send_gap_pct = 0;
  int       stall_pct    = 0;

  quad_attitude_pid_mixer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("quad_attitude_pid_mixer verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // ---------------- predictor ----------------

  function automatic longint gain(gain_reg_e r);
    return longint'(gain_regs[r]);
  endfunction

  function automatic longint accumulate(axis_e ax, longint err, longint ki);
    longint s;
    s = integ[ax] + ((ki * err + RND16) >>> 16);
    if (s > INT_LIM) s = INT_LIM;
    else if (s < -INT_LIM) s = -INT_LIM;
    integ[ax] = s;
    return s;
  endfunction

  function automatic longint axis_loop(axis_e ax, logic [STK_W-1:0] stick,
                                       logic signed [ANG_W-1:0] angle,
                                       logic signed [ANG_W-1:0] rate,
                                       longint kp, longint ki, longint kd);
    longint dev, num, setpt, err, acc;
    dev = longint'(stick) - STICK_MID;
    // setpoint = 0.03 deg per us in Q.8, rounded half up (floor division)
    num = 384 * dev + 25;
    setpt = (num >= 0) ? num / 50 : -((-num + 49) / 50);
    err = longint'($signed(angle)) - setpt;
    acc = accumulate(ax, err, ki);
    return kp * err + kd * longint'($signed(rate)) + acc * 256;
  endfunction

  function automatic logic [MOT_W-1:0] motor_level(longint m);
    longint q;
    if (m < 0) return '0;
    q = (m + RND16) >>> 16;
    if (q > MOTOR_MAX) q = MOTOR_MAX;
    return q[MOT_W-1:0];
  endfunction

  function automatic out_t predict_motors(in_t t);
    out_t   res;
    longint thr, p, r, y, yaw_err, tq, s0, s12, s3;
    thr = longint'(t.rc_throttle);
    if (t.reset_integrators) begin
      integ[AX_PITCH] = 0;
      integ[AX_ROLL]  = 0;
      integ[AX_YAW]   = 0;
    end
    if (thr <= THR_CUTOFF) return '0;
    p = axis_loop(AX_PITCH, t.rc_pitch_stick, t.pitch_angle, t.pitch_rate,
                  gain(REG_KP_PITCH), gain(REG_KI_PITCH), gain(REG_KD_PITCH));
    r = axis_loop(AX_ROLL, t.rc_roll_stick, t.roll_angle, t.roll_rate,
                  gain(REG_KP_ROLL), gain(REG_KI_ROLL), gain(REG_KD_ROLL));
    yaw_err = longint'($signed(t.yaw_rate));
    y = gain(REG_KP_YAW) * yaw_err + accumulate(AX_YAW, yaw_err, gain(REG_KI_YAW)) * 256;
    tq  = thr - THR_BASE;
    s0  = (tq * 98 * ONE_Q24) / 1000;
    s12 = (tq * ONE_Q24) / 10;
    s3  = (tq * 95 * ONE_Q24) / 1000;
    res.motor_0 = motor_level(s0 + p + r + y);
    res.motor_1 = motor_level(s12 + p - r - y);
    res.motor_2 = motor_level(s12 - p - r + y);
    res.motor_3 = motor_level(s3 - p + r - y);
    return res;
  endfunction

  // ---------------- result checking ----------------

  task automatic check_motors(input out_t got);
    out_t             want;
    logic [MOT_W-1:0] g [4];
    logic [MOT_W-1:0] w [4];
    if (motor_queue.size() == 0) begin
      report_mismatch($sformatf("motor transfer %h with no tick pending", got));
      return;
    end
    want = motor_queue.pop_front();
    g = '{got.motor_0, got.motor_1, got.motor_2, got.motor_3};
    w = '{want.motor_0, want.motor_1, want.motor_2, want.motor_3};
    for (int i = 0; i < 4; i++)
      if (g[i] !== w[i])
        report_mismatch($sformatf("result %0d motor_%0d: got %0d, predicted %0d",
                                  result_count, i, g[i], w[i]));
    result_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_motors(out_data);
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // ---------------- register port ----------------

  task automatic write_gain(input gain_reg_e r, input logic [GAIN_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * r);
    pwdata  <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    gain_regs[r] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_gain(input gain_reg_e r);
    logic [DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * r);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== DATA_W'(gain_regs[r]))
      report_mismatch($sformatf("gain register %s reads %0d, holds %0d",
                                r.name(), rd, gain_regs[r]));
    @(negedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] gain_plan(int phase, gain_reg_e r);
    bit is_ki;
    is_ki = (r == REG_KI_PITCH) || (r == REG_KI_ROLL) || (r == REG_KI_YAW);
    case (phase)
      0: return RESET_GAIN[r];
      1: return '1;
      2: return '0;
      3: return GAIN_W'($urandom());
      4: return is_ki ? GAIN_W'($urandom_range(0, 1 << 20)) : GAIN_W'($urandom_range(0, 1 << 17));
      default: return is_ki ? '1 : GAIN_W'($urandom_range(0, 1 << 15));
    endcase
  endfunction

  // ---------------- stimulus ----------------

  task automatic set_idle(input idle_mode_e mode);
    send_gap_pct = (mode == IDLE_SENDER) ? 84 : (mode == IDLE_BOTH) ? 23 : 0;
    stall_pct    = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 23 : 0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_tick(input in_t t, input bit typed, input out_t typed_motors);
    out_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_motors(t);
    motor_queue.push_back(typed ? typed_motors : pred);
    @(negedge clk);
  endtask

  // Hold off until every pending result has come and the sequencer has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (motor_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void add_row(bit rst, int thr, int ps, int rs, int pa, int pr,
                                  int ra, int rr, int yr, bit typed = 1'b0,
                                  int m0 = 0, int m1 = 0, int m2 = 0, int m3 = 0);
    dir_row_t row;
    row.tick.reset_integrators = rst;
    row.tick.rc_throttle    = thr[STK_W-1:0];
    row.tick.rc_pitch_stick = ps[STK_W-1:0];
    row.tick.rc_roll_stick  = rs[STK_W-1:0];
    row.tick.pitch_angle    = pa[ANG_W-1:0];
    row.tick.pitch_rate     = pr[ANG_W-1:0];
    row.tick.roll_angle     = ra[ANG_W-1:0];
    row.tick.roll_rate      = rr[ANG_W-1:0];
    row.tick.yaw_rate       = yr[ANG_W-1:0];
    row.typed  = typed;
    row.motors = '{m0[MOT_W-1:0], m1[MOT_W-1:0], m2[MOT_W-1:0], m3[MOT_W-1:0]};
    dir_rows.push_back(row);
  endfunction

  function automatic void build_dir_rows();
    localparam int AMAX = 8388607;
    localparam int AMIN = -8388608;
    //      rst thr   pstk  rstk  p_ang  p_rate r_ang  r_rate yaw    typed motors
    add_row(1, 2000, 1500, 1500, 0,     0,     0,     0,     0,     1, 25088, 25600, 25600, 24320);
    add_row(1, 4095, 1500, 1500, 0,     0,     0,     0,     0,     1, 25600, 25600, 25600, 25600);
    add_row(0, 1100, 1500, 1500, 2560,  512,   -2560, 100,   300,   1);
    add_row(1, 1101, 1500, 1500, 0,     0,     0,     0,     0);
    add_row(0, 0,    4095, 4095, AMAX,  AMAX,  AMAX,  AMAX,  AMAX,  1);
    add_row(0, 1500, 0,    4095, 0,     0,     0,     0,     0);
    add_row(0, 1500, 4095, 0,    0,     0,     0,     0,     0);
    add_row(1, 1500, 1500, 1500, AMAX,  0,     0,     0,     0);
    add_row(0, 1500, 1500, 1500, AMIN,  0,     0,     0,     0);
    add_row(1, 1600, 1500, 1500, 0,     0,     AMAX,  AMIN,  0);
    add_row(0, 1600, 1500, 1500, 0,     0,     AMIN,  AMAX,  0);
    add_row(1, 1700, 1500, 1500, 0,     AMAX,  0,     0,     0);
    add_row(0, 1700, 1500, 1500, 0,     AMIN,  0,     0,     0);
    add_row(1, 1800, 1500, 1500, 0,     0,     0,     0,     AMAX);
    add_row(0, 1800, 1500, 1500, 0,     0,     0,     0,     AMIN);
    // integrator clear must act even when the throttle is cut
    add_row(1, 500,  1500, 1500, 5000,  0,     5000,  0,     5000,  1);
    add_row(0, 2000, 1500, 1500, 0,     0,     0,     0,     0,     1, 25088, 25600, 25600, 24320);
    add_row(1, 4095, 4095, 4095, AMAX,  AMAX,  AMAX,  AMAX,  AMAX);
    add_row(0, 1101, 0,    0,    AMIN,  AMIN,  AMIN,  AMIN,  AMIN);
    add_row(1, 1600, 1500, 1500, 2560,  -1280, 0,     0,     0);
    add_row(0, 1550, 1700, 1300, -1024, 768,   1536,  -640,  2048);
    add_row(0, 1650, 1250, 1800, 3000,  -200,  -4000, 900,   -1500);
  endfunction

  function automatic logic [ANG_W-1:0] rand_q8(int span);
    int v;
    if ($urandom_range(3) == 0) return ANG_W'($urandom());
    v = int'($urandom_range(2 * span)) - span;
    return v[ANG_W-1:0];
  endfunction

  function automatic in_t rand_tick();
    in_t t;
    int  sel;
    t.reset_integrators = ($urandom_range(99) < 4);
    sel = $urandom_range(9);
    if (sel == 0) t.rc_throttle = STK_W'($urandom());
    else if (sel == 1) t.rc_throttle = STK_W'($urandom_range(0, THR_CUTOFF));
    else t.rc_throttle = STK_W'($urandom_range(THR_CUTOFF + 1, 2000));
    t.rc_pitch_stick = ($urandom_range(6) == 0) ? STK_W'($urandom())
                                                : STK_W'($urandom_range(1000, 2000));
    t.rc_roll_stick  = ($urandom_range(6) == 0) ? STK_W'($urandom())
                                                : STK_W'($urandom_range(1000, 2000));
    // angles within +-45 deg and rates within +-500 deg/s most of the time
    t.pitch_angle = rand_q8(11520);
    t.pitch_rate  = rand_q8(128000);
    t.roll_angle  = rand_q8(11520);
    t.roll_rate   = rand_q8(128000);
    t.yaw_rate    = rand_q8(128000);
    return t;
  endfunction

  initial begin
    idle_mode_e mode;
    integ = '{0, 0, 0};
    for (int i = 0; i < NUM_GAIN_REGS; i++) gain_regs[i] = RESET_GAIN[i];
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_GAIN_REGS; i++) check_gain(gain_reg_e'(i));

    build_dir_rows();
    set_idle(IDLE_NONE);
    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].motors);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      for (int i = 0; i < NUM_GAIN_REGS; i++) begin
        write_gain(gain_reg_e'(i), gain_plan(phase, gain_reg_e'(i)));
        check_gain(gain_reg_e'(i));
      end
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // later phases rotate through every idle pattern
        mode = (phase < 4) ? idle_mode_e'(phase) : idle_mode_e'((n / 40) % 4);
        set_idle(mode);
        if (n == PHASE_TICKS / 2) drain();
        send_tick(rand_tick(), 1'b0, '0);
      end
      drain();
    end

    set_idle(IDLE_NONE);
    drain();
    if (fail_count == 0) begin
      $display("quad_attitude_pid_mixer verification clean");
    end else begin
      $display("quad_attitude_pid_mixer verification failed");
    end
    $finish;
  end

endmodule
